FILE: sv/ltc_pkg.sv
// Package for the lexical token classifier: result kind codes, the keyword
// table and the character class functions.
// No dependencies.
`default_nettype none

package ltc_pkg;

  localparam int KwTableSize = 20;
  localparam int KwMaxLen = 8;

  typedef enum logic [2:0] {
    KIND_KEYWORD    = 3'd0,
    KIND_IDENTIFIER = 3'd1,
    KIND_CONSTANT   = 3'd2,
    KIND_INVALID    = 3'd3,
    KIND_OPERATOR   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  keyword_number;
    logic [7:0]  token_length;
    logic [7:0]  operator_char;
    logic        last;
  } result_t;

  typedef logic [7:0] kw_word_t [KwMaxLen];

  localparam kw_word_t KwText [KwTableSize] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
    '{"l", "o", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "i", "z", "e", "o", "f", 8'h00, 8'h00},
    '{"s", "w", "i", "t", "c", "h", 8'h00, 8'h00},
    '{"u", "n", "s", "i", "g", "n", "e", "d"},
    '{"s", "i", "g", "n", "e", "d", 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "a", "t", "i", "c", 8'h00, 8'h00},
    '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
    '{"g", "o", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] KwLen [KwTableSize] = '{
    4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd5, 4'd8, 4'd3, 4'd5, 4'd6,
    4'd4, 4'd4, 4'd6, 4'd6, 4'd8, 4'd6, 4'd4, 4'd6, 4'd6, 4'd4
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c inside {"=", "+", "-", "*", "/", "%"};
  endfunction

  function automatic logic is_delimiter(input logic [7:0] c);
    return is_operator(c) ||
           (c inside {" ", "(", ")", "[", "]", "{", "}", ",", ";", "<", ">"});
  endfunction

endpackage

`default_nettype wire

FILE: sv/ltc_char_if.sv
// Character channel of the lexical token classifier: valid, ready and one
// source character per transaction. No dependencies.
`default_nettype none

interface ltc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink (input valid, input char_code, input line_end, output ready);
endinterface

`default_nettype wire

FILE: sv/ltc_token_if.sv
// Token result channel of the lexical token classifier: valid, ready and one
// classified token or operator per transaction. No dependencies.
`default_nettype none

interface ltc_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [4:0] keyword_number;
  logic [7:0] token_length;
  logic [7:0] operator_char;
  logic       last;

  modport source (output valid, output token_kind, output keyword_number,
                  output token_length, output operator_char, output last,
                  input ready);
  modport sink (input valid, input token_kind, input keyword_number,
                input token_length, input operator_char, input last,
                output ready);
endinterface

`default_nettype wire

FILE: sv/lexical_token_classifier_unit.sv
// Top level of the lexical token classifier.
// Depends on ltc_pkg, ltc_char_if and ltc_token_if.
`default_nettype none

// The block takes one source character per cycle and classifies each token
// when a delimiter ends it, tracking keyword prefixes one position at a time.
// A character transaction is accepted in every cycle while the four-entry
// result queue has room for two results. The first result of a character can
// leave in the cycle after the character is accepted, and a second result
// follows it. Results leave the queue one per cycle while tokens.ready is
// high. A character gives zero, one or two results, so characters are taken
// at one per cycle as long as they average no more than one result each;
// beyond that the single result port sets the rate and the input stalls.
// Line end drops the pending token and gives no result.
module lexical_token_classifier_unit #(
  parameter int KEYWORD_COUNT = 20,
  parameter int LENGTH_LIMIT  = 255
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ltc_char_if.sink     chars,
  ltc_token_if.source  tokens
);

  localparam int KwUsed = (KEYWORD_COUNT < ltc_pkg::KwTableSize) ?
                          KEYWORD_COUNT : ltc_pkg::KwTableSize;
  localparam int LenW = $clog2(LENGTH_LIMIT + 1);
  localparam int Depth = 4;
  localparam int PtrW = 2;

  logic [KwUsed-1:0] keyword_alive, keyword_alive_next;
  logic [LenW-1:0]   pending_length, pending_length_next;
  logic              starts_with_digit, starts_with_digit_next;
  logic              all_digits, all_digits_next;

  ltc_pkg::result_t  queue [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW:0]     count, count_next;

  logic              accept, pop, is_delim, is_op, tok_push, found;
  logic [4:0]        kw_hit;
  ltc_pkg::kind_t    tok_kind;
  ltc_pkg::result_t  tok_res, op_res, first_res;
  logic [1:0]        push_n;

  assign chars.ready = (count <= (PtrW + 1)'(Depth - 2));
  assign accept = chars.valid && chars.ready;
  assign pop = tokens.valid && tokens.ready;

  assign is_delim = ltc_pkg::is_delimiter(chars.char_code);
  assign is_op = ltc_pkg::is_operator(chars.char_code);

  always_comb begin
    found = 1'b0;
    kw_hit = '0;
    for (int k = KwUsed - 1; k >= 0; k--) begin
      if (keyword_alive[k] && (LenW'(ltc_pkg::KwLen[k]) == pending_length)) begin
        found = 1'b1;
        kw_hit = 5'(k);
      end
    end
    if (found) begin
      tok_kind = ltc_pkg::KIND_KEYWORD;
    end else if (!starts_with_digit) begin
      tok_kind = ltc_pkg::KIND_IDENTIFIER;
    end else if (all_digits) begin
      tok_kind = ltc_pkg::KIND_CONSTANT;
    end else begin
      tok_kind = ltc_pkg::KIND_INVALID;
    end
  end

  always_comb begin
    tok_res.kind = tok_kind;
    tok_res.keyword_number = kw_hit;
    tok_res.token_length = 8'(pending_length);
    tok_res.operator_char = 8'h00;
    tok_res.last = !is_op;
    op_res.kind = ltc_pkg::KIND_OPERATOR;
    op_res.keyword_number = 5'd0;
    op_res.token_length = 8'd1;
    op_res.operator_char = chars.char_code;
    op_res.last = 1'b1;
  end

  assign tok_push = accept && !chars.line_end && is_delim && (pending_length != '0);
  assign first_res = tok_push ? tok_res : op_res;
  assign push_n = (accept && !chars.line_end && is_delim) ?
                  (2'(tok_push) + 2'(is_op)) : 2'd0;

  always_comb begin
    keyword_alive_next = keyword_alive;
    pending_length_next = pending_length;
    starts_with_digit_next = starts_with_digit;
    all_digits_next = all_digits;
    if (accept) begin
      if (chars.line_end || is_delim) begin
        keyword_alive_next = '1;
        pending_length_next = '0;
        starts_with_digit_next = 1'b0;
        all_digits_next = 1'b1;
      end else begin
        for (int k = 0; k < KwUsed; k++) begin
          keyword_alive_next[k] = keyword_alive[k] &&
              (pending_length < LenW'(ltc_pkg::KwLen[k])) &&
              (ltc_pkg::KwText[k][pending_length[2:0]] == chars.char_code);
        end
        if (pending_length == '0) begin
          starts_with_digit_next = ltc_pkg::is_digit(chars.char_code);
        end
        if (!ltc_pkg::is_digit(chars.char_code)) begin
          all_digits_next = 1'b0;
        end
        if (pending_length < LenW'(LENGTH_LIMIT)) begin
          pending_length_next = pending_length + LenW'(1);
        end
      end
    end
  end

  assign count_next = count + (PtrW + 1)'(push_n) - (PtrW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_alive <= '1;
      pending_length <= '0;
      starts_with_digit <= 1'b0;
      all_digits <= 1'b1;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      keyword_alive <= keyword_alive_next;
      pending_length <= pending_length_next;
      starts_with_digit <= starts_with_digit_next;
      all_digits <= all_digits_next;
      wr_ptr <= wr_ptr + PtrW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= first_res;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + PtrW'(1)] <= op_res;
    end
  end

  assign tokens.valid = (count != '0);
  assign tokens.token_kind = queue[rd_ptr].kind;
  assign tokens.keyword_number = queue[rd_ptr].keyword_number;
  assign tokens.token_length = queue[rd_ptr].token_length;
  assign tokens.operator_char = queue[rd_ptr].operator_char;
  assign tokens.last = queue[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PtrW + 1)'(Depth))
    else $error("result queue count exceeds its depth");

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.line_end) |=> (pending_length == '0) && (&keyword_alive))
    else $error("line end did not clear the pending token");

  a_keyword_short: assert property (@(posedge clk) disable iff (rst)
    (tok_push && found) |-> (pending_length <= LenW'(ltc_pkg::KwMaxLen)))
    else $error("keyword result longer than any keyword");

endmodule

`default_nettype wire
